@@ rtl/rsst_pkg.sv @@
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared constants, operation codes and types of the range sum segment tree.
// ----------------------------------------------------------------------------
package rsst_pkg;

  // Tree geometry: 1024 leaves, already a power of two, so no padding.
  localparam int unsigned Leaves    = 1024;
  localparam int unsigned LeafW     = 10;
  localparam int unsigned NodeAddrW = 11;
  localparam int unsigned NodeDepth = 2048;
  // Heap positions of the query walk can reach 2048, one bit more.
  localparam int unsigned PosW      = 12;
  localparam int unsigned DataW     = 32;

  // Operation codes.
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Write port of the node memory.
  typedef struct packed {
    logic                 we;
    logic [NodeAddrW-1:0] addr;
    logic [DataW-1:0]     data;
  } rsst_wr_t;

endpackage

@@ rtl/range_sum_segment_tree_unit.sv @@
// ----------------------------------------------------------------------------
// range_sum_segment_tree_unit
// Segment tree over 1024 signed 32-bit leaves with point set, point add,
// point read and half-open range sum, all wrapping modulo 2^32.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op_i, index_lo_i, index_hi_i, value_i) is taken at a rising edge
//   where start_i is high and busy_o is low. Get and query items give one
//   result on sum_o, shown for exactly one cycle with result_valid_o high;
//   set and add items give no result. The receiver cannot stall the block.
// Sequencing:
//   The nodes sit in one dual-port RAM with a registered read, and one adder
//   does all the arithmetic. Get reads the leaf and registers it as the
//   result. Set and add do one leaf read, then for each of the 11 levels
//   a node write with a sibling read, and one add per parent. A query walks
//   bottom-up through a left-bound and a right-bound state for each level
//   that it visits, with at most one RAM read per state.
// Reset:
//   After reset a clearing sweep writes zero to all 2048 RAM entries, one per
//   cycle; busy_o stays high until the sweep is done.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_unit
  import rsst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              op_i,
  input  logic [LeafW-1:0]        index_lo_i,
  input  logic [LeafW:0]          index_hi_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] sum_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_LEAF_WAIT = 3'd1;
  localparam logic [2:0] S_UP_WR     = 3'd2;
  localparam logic [2:0] S_UP_SUM    = 3'd3;
  localparam logic [2:0] S_Q_L       = 3'd4;
  localparam logic [2:0] S_Q_R       = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [1:0]           op_q, op_d;
  logic [DataW-1:0]     val_q, val_d;
  logic [DataW-1:0]     cur_q, cur_d;
  logic [NodeAddrW-1:0] pos_q, pos_d;
  logic [PosW-1:0]      l_q, l_d;
  logic [PosW-1:0]      r_q, r_d;
  logic                 pend_q, pend_d;
  logic                 valid_q, valid_d;
  logic [DataW-1:0]     sum_q, sum_d;

  logic                 clr_active;
  rsst_wr_t             clr_wr;
  rsst_wr_t             seq_wr;
  rsst_wr_t             ram_wr;
  logic [NodeAddrW-1:0] raddr;
  logic [DataW-1:0]     rdata;
  logic [DataW-1:0]     add_a, add_b, add_res;
  logic [LeafW:0]       hi_clamp;
  logic [PosW-1:0]      r_dec;

  // Zeroing sweep after reset.
  rsst_clear u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .active_o(clr_active),
    .wr_o    (clr_wr)
  );

  // The sweep owns the write port until it is done.
  assign ram_wr = clr_active ? clr_wr : seq_wr;

  rsst_ram #(
    .Width(DataW),
    .Depth(NodeDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_wr.we),
    .waddr_i(ram_wr.addr),
    .wdata_i(ram_wr.data),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Operand selection for the shared adder.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_LEAF_WAIT: begin
        add_a = (op_q == OP_SET) ? '0 : rdata;
        add_b = (op_q == OP_SET || op_q == OP_ADD) ? val_q : '0;
      end
      S_UP_SUM: begin
        add_a = rdata;
        add_b = cur_q;
      end
      S_Q_L, S_Q_R: begin
        add_a = pend_q ? rdata : '0;
        add_b = cur_q;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_res  = add_a + add_b;
  assign hi_clamp = (index_hi_i > (LeafW + 1)'(Leaves)) ? (LeafW + 1)'(Leaves) : index_hi_i;
  assign r_dec    = r_q - PosW'(1);

  // Sequencer. Every leaf index fits below Leaves; only index_hi_i is clamped to Leaves.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    l_d         = l_q;
    r_d         = r_q;
    pend_d      = pend_q;
    valid_d     = 1'b0;
    sum_d       = sum_q;
    raddr       = {1'b1, index_lo_i};
    seq_wr.we   = 1'b0;
    seq_wr.addr = pos_q;
    seq_wr.data = cur_q;
    case (state_q)
      S_IDLE: begin
        pend_d = 1'b0;
        cur_d  = '0;
        if (start_i && !clr_active) begin
          op_d  = op_i;
          val_d = value_i;
          pos_d = {1'b1, index_lo_i};
          l_d   = PosW'(index_lo_i) + PosW'(Leaves);
          r_d   = PosW'(hi_clamp) + PosW'(Leaves);
          if (op_i == OP_QUERY) begin
            state_d = S_Q_L;
          end else begin
            state_d = S_LEAF_WAIT;
          end
        end
      end
      // Leaf value is back from the RAM.
      S_LEAF_WAIT: begin
        if (op_q == OP_GET) begin
          sum_d   = add_res;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d   = add_res;
          state_d = S_UP_WR;
        end
      end
      // Store the node and fetch its sibling; the root ends the walk.
      S_UP_WR: begin
        seq_wr.we = 1'b1;
        raddr     = pos_q ^ NodeAddrW'(1);
        if (pos_q == NodeAddrW'(1)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_UP_SUM;
        end
      end
      // Parent sum from the node and its sibling.
      S_UP_SUM: begin
        cur_d   = add_res;
        pos_d   = pos_q >> 1;
        state_d = S_UP_WR;
      end
      // Query: fold in the pending node, then take the left bound, or end once left is not below right.
      S_Q_L: begin
        if (l_q < r_q) begin
          cur_d  = add_res;
          pend_d = l_q[0];
          raddr  = l_q[NodeAddrW-1:0];
          if (l_q[0]) begin
            l_d = l_q + PosW'(1);
          end
          state_d = S_Q_R;
        end else begin
          sum_d   = add_res;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      // Query: fold in the pending node, take the right bound, go up a level.
      S_Q_R: begin
        cur_d   = add_res;
        pend_d  = r_q[0];
        raddr   = r_dec[NodeAddrW-1:0];
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = S_Q_L;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    cur_q <= cur_d;
    pos_q <= pos_d;
    l_q   <= l_d;
    r_q   <= r_d;
    sum_q <= sum_d;
  end

  assign busy_o         = clr_active || (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign sum_o          = sum_q;

  // The sequencer never runs while the clearing sweep owns the RAM.
  a_no_work_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> (state_q == S_IDLE))
    else $error("sequencer active during clearing sweep");

  // Every item passes through a state beyond idle, so results never come back to back.
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  // Path updates never write the unused node zero.
  a_update_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_WR) |-> (pos_q != '0))
    else $error("path update addresses node zero");

  // A result only follows a get or a query.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(op_q) == OP_GET || $past(op_q) == OP_QUERY))
    else $error("result from an update item");

endmodule

@@ rtl/rsst_ram.sv @@
// ----------------------------------------------------------------------------
// rsst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rsst_clear.sv @@
// ----------------------------------------------------------------------------
// rsst_clear
// Clearing sweep after reset: writes zero to every node, one per cycle.
// ----------------------------------------------------------------------------
module rsst_clear
  import rsst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  output logic     active_o,
  output rsst_wr_t wr_o
);

  logic [NodeAddrW-1:0] addr_q, addr_d;
  logic                 active_q, active_d;

  // Step through the memory and stop after the last entry.
  always_comb begin
    addr_d   = addr_q;
    active_d = active_q;
    if (active_q) begin
      addr_d = addr_q + NodeAddrW'(1);
      if (addr_q == NodeAddrW'(NodeDepth - 1)) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      active_q <= 1'b1;
    end else begin
      addr_q   <= addr_d;
      active_q <= active_d;
    end
  end

  assign active_o = active_q;
  assign wr_o.we   = active_q;
  assign wr_o.addr = addr_q;
  assign wr_o.data = '0;

endmodule
